>>> design/brac_pkg.sv
// ----------------------------------------------------------------------------
// brac_pkg
// Shared stage types and field widths for the buffer address check pipeline.
// ----------------------------------------------------------------------------
package brac_pkg;

    localparam int unsigned AddrW  = 48;
    localparam int unsigned NrecW  = 45;
    localparam int unsigned StrW   = 16;
    localparam int unsigned WordW  = 32;
    localparam int unsigned IoffW  = 24;
    localparam int unsigned PartW  = 34;
    localparam int unsigned ProdW  = 48;
    localparam int unsigned TotW   = 50;
    localparam int unsigned InDataW  = 256;
    localparam int unsigned InUserW  = 2;
    localparam int unsigned OutDataW = 48;
    localparam int unsigned OutUserW = 2;

    typedef struct packed {
        logic [AddrW-1:0]        base;
        logic [NrecW-1:0]        nrec;
        logic [StrW-1:0]         stride;
        logic                    strided;
        logic [WordW-1:0]        index;
        logic signed [PartW-1:0] part;
        logic [WordW-1:0]        soff;
        logic                    active;
    } t_s1;

    typedef struct packed {
        logic [AddrW-1:0]        base;
        logic [ProdW-1:0]        prod;
        logic signed [PartW-1:0] part;
        logic [WordW-1:0]        soff;
        logic                    rec_fail;
        logic                    active;
    } t_s2;

    typedef struct packed {
        logic [AddrW-1:0] base;
        logic [AddrW-1:0] total;
        logic             oob;
        logic             active;
    } t_s3;

endpackage

>>> design/brac_decode.sv
// ----------------------------------------------------------------------------
// brac_decode
// Descriptor decode, index and offset select, partial offset sum.
// ----------------------------------------------------------------------------
module brac_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [brac_pkg::InDataW-1:0]        i_tdata,
    input  logic [brac_pkg::InUserW-1:0]        i_tuser,
    output logic                                o_valid,
    output brac_pkg::t_s1                       o_stage
);

    logic [31:0] w0, w1, w2, w3, v0, v1, soff;
    logic [23:0] ioff;
    logic        idxen, offen, active;
    logic [31:0] index, voff;
    logic [15:0] stride;

    logic          r_valid;
    brac_pkg::t_s1 r_stage;
    brac_pkg::t_s1 n_stage;

    assign w0     = i_tdata[31:0];
    assign w1     = i_tdata[63:32];
    assign w2     = i_tdata[95:64];
    assign w3     = i_tdata[127:96];
    assign v0     = i_tdata[159:128];
    assign v1     = i_tdata[191:160];
    assign ioff   = i_tdata[215:192];
    assign soff   = i_tdata[247:216];
    assign active = i_tdata[248];
    assign idxen  = i_tuser[0];
    assign offen  = i_tuser[1];
    assign stride = w3[27:12];

    always_comb begin
        index = '0;
        voff  = '0;
        if (idxen && offen) begin
            index = v0;
            voff  = v1;
        end else if (idxen) begin
            index = v0;
        end else if (offen) begin
            voff = v0;
        end
        n_stage.base    = {w1[15:0], w0};
        n_stage.nrec    = {w3[5:0], w2, w1[31:25]};
        n_stage.stride  = stride;
        n_stage.strided = !w3[31] && (stride != '0);
        n_stage.index   = index;
        n_stage.part    = $signed({2'b00, voff}) + $signed({{10{ioff[23]}}, ioff});
        n_stage.soff    = soff;
        n_stage.active  = active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> design/brac_mult.sv
// ----------------------------------------------------------------------------
// brac_mult
// Index times stride product and record count compares.
// ----------------------------------------------------------------------------
module brac_mult (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  brac_pkg::t_s1 i_stage,
    output logic          o_valid,
    output brac_pkg::t_s2 o_stage
);

    logic          ge_idx, ge_part;
    logic          r_valid;
    brac_pkg::t_s2 r_stage;
    brac_pkg::t_s2 n_stage;

    assign ge_idx  = {13'd0, i_stage.index} >= i_stage.nrec;
    assign ge_part = {11'd0, i_stage.part} >= i_stage.nrec;

    always_comb begin
        n_stage.base     = i_stage.base;
        n_stage.prod     = {16'd0, i_stage.index} * {32'd0, i_stage.stride};
        n_stage.part     = i_stage.part;
        n_stage.soff     = i_stage.soff;
        n_stage.rec_fail = (i_stage.nrec != '0) && (i_stage.strided ? ge_idx : ge_part);
        n_stage.active   = i_stage.active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> design/brac_bound.sv
// ----------------------------------------------------------------------------
// brac_bound
// Total offset sum, negative offset check and out-of-bounds flag merge.
// ----------------------------------------------------------------------------
module brac_bound (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  brac_pkg::t_s2 i_stage,
    output logic          o_valid,
    output brac_pkg::t_s3 o_stage
);

    logic signed [brac_pkg::TotW-1:0] total;
    logic          r_valid;
    brac_pkg::t_s3 r_stage;
    brac_pkg::t_s3 n_stage;

    assign total = $signed({2'b00, i_stage.prod})
                 + $signed({{16{i_stage.part[33]}}, i_stage.part})
                 + $signed({18'd0, i_stage.soff});

    always_comb begin
        n_stage.base   = i_stage.base;
        n_stage.total  = total[brac_pkg::AddrW-1:0];
        n_stage.oob    = total[brac_pkg::TotW-1] || i_stage.part[brac_pkg::PartW-1]
                       || i_stage.rec_fail;
        n_stage.active = i_stage.active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> design/buffer_resource_address_check_unit.sv
// ----------------------------------------------------------------------------
// buffer_resource_address_check_unit
// Per-lane buffer address generation with descriptor bounds check.
// ----------------------------------------------------------------------------
// One request carries a lane's four descriptor words, two vector register
// values, the instruction and scalar offsets and the exec bit on the slave
// stream; one result with the 48-bit address and two status flags leaves on
// the master stream for every request.
// A request passes decode and offset select, the 32x16 index-stride multiply,
// the wide offset sum, and the final base add into the output register, each
// registered. Throughput is one request per cycle when the output is not held.
// Inactive lanes return address 0 with both flags low; lanes that fail the
// bounds check return address 0 with out_of_range set.
// All stages advance together: when the output holds a result that the
// receiver does not take, the whole pipeline and o_s_axis_tready hold, and
// nothing is dropped or repeated.
// Reset clears every stage's valid bit; the first request can be taken in the
// cycle after reset is released.
// ----------------------------------------------------------------------------
module buffer_resource_address_check_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // descriptor_word0..3, first_vector_value, second_vector_value,
    // inst_offset, scalar_offset, lane_active, zero pad
    input  logic [brac_pkg::InDataW-1:0]  i_s_axis_tdata,
    // index_enable, offset_enable
    input  logic [brac_pkg::InUserW-1:0]  i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // address
    output logic [brac_pkg::OutDataW-1:0] o_m_axis_tdata,
    // lane_enabled, out_of_range
    output logic [brac_pkg::OutUserW-1:0] o_m_axis_tuser
);

    logic          en;
    logic          s1_valid, s2_valid, s3_valid;
    brac_pkg::t_s1 s1;
    brac_pkg::t_s2 s2;
    brac_pkg::t_s3 s3;

    logic                      r_valid;
    logic [brac_pkg::AddrW-1:0] r_addr;
    logic                      r_lane_en;
    logic                      r_oor;
    logic [brac_pkg::AddrW-1:0] n_addr;
    logic                      n_lane_en;
    logic                      n_oor;

    assign en              = !r_valid || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;

    brac_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_tdata (i_s_axis_tdata),
        .i_tuser (i_s_axis_tuser),
        .o_valid (s1_valid),
        .o_stage (s1)
    );

    brac_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_stage (s1),
        .o_valid (s2_valid),
        .o_stage (s2)
    );

    brac_bound u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s2_valid),
        .i_stage (s2),
        .o_valid (s3_valid),
        .o_stage (s3)
    );

    always_comb begin
        n_lane_en = s3.active && !s3.oob;
        n_oor     = s3.active && s3.oob;
        n_addr    = n_lane_en ? (s3.base + s3.total) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_addr    <= n_addr;
            r_lane_en <= n_lane_en;
            r_oor     <= n_oor;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_addr;
    assign o_m_axis_tuser  = {r_oor, r_lane_en};

endmodule

>>> design/brac_checker.sv
// ----------------------------------------------------------------------------
// brac_checker
// Port-level checks on the buffer address check unit's result stream.
// ----------------------------------------------------------------------------
module brac_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [brac_pkg::OutDataW-1:0] o_m_axis_tdata,
    input logic [brac_pkg::OutUserW-1:0] o_m_axis_tuser
);

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("lane enabled and out of range together");

    a_disabled_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("disabled lane with nonzero address");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    a_ready_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("request blocked with room in the pipeline");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind buffer_resource_address_check_unit brac_checker u_brac_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> tb/sv/tb_buffer_resource_address_check_unit.sv
// ----------------------------------------------------------------------------
// tb_buffer_resource_address_check_unit
// Self-checking bench for the per-lane buffer address and bounds check unit.
// ----------------------------------------------------------------------------
// Lane requests go in on the slave stream in random bursts, results are taken
// on the master stream under a changing back-pressure pattern. Every accepted
// request is run through a local address model and the expected result is
// queued; each result is compared field by field with the oldest entry.
// A directed set covers the field extremes, every enable combination, both
// bounds modes, zero record count, negative offsets and 48-bit wrap; random
// lanes then stress the record-count boundaries.
// ----------------------------------------------------------------------------
module tb_buffer_resource_address_check_unit;

    localparam int unsigned IdleLimit    = 2000;
    localparam int unsigned RandomLanes  = 1350;
    localparam int unsigned DrainCycles  = 20;
    localparam int unsigned MaxPrinted   = 40;

    typedef struct packed {
        logic [31:0]        w0;
        logic [31:0]        w1;
        logic [31:0]        w2;
        logic [31:0]        w3;
        logic [31:0]        v0;
        logic [31:0]        v1;
        logic signed [23:0] ioff;
        logic [31:0]        soff;
        logic               index_en;
        logic               offset_en;
        logic               active;
    } t_lane_request;

    typedef struct packed {
        logic [47:0] address;
        logic        lane_enabled;
        logic        out_of_range;
    } t_lane_result;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_LONG_STALL
    } t_ready_mode;

    class lane_address_board;
        t_lane_result pending_addresses[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function t_lane_result lane_address_of(t_lane_request r);
            logic [56:0]  base;
            logic [44:0]  count;
            logic [15:0]  stride;
            logic         raw;
            logic [31:0]  index;
            logic [31:0]  voff;
            longint       ioff_ext;
            longint       part;
            longint       total;
            logic [63:0]  sum;
            logic         oob;
            t_lane_result res;
            base     = {r.w1[24:0], r.w0};
            count    = {r.w3[5:0], r.w2, r.w1[31:25]};
            stride   = r.w3[27:12];
            raw      = r.w3[31];
            index    = '0;
            voff     = '0;
            ioff_ext = {{40{r.ioff[23]}}, r.ioff};
            res      = '0;
            if (!r.active) begin
                return res;
            end
            if (r.index_en) begin
                index = r.v0;
                if (r.offset_en) begin
                    voff = r.v1;
                end
            end else if (r.offset_en) begin
                voff = r.v0;
            end
            part  = longint'({32'd0, voff}) + ioff_ext;
            total = longint'({32'd0, index}) * longint'({48'd0, stride}) + part
                    + longint'({32'd0, r.soff});
            oob   = (total < 0) || (part < 0);
            if (!oob && count != '0) begin
                if (!raw && stride != '0) begin
                    oob = {13'd0, index} >= count;
                end else begin
                    oob = part >= longint'({19'd0, count});
                end
            end
            if (oob) begin
                res.out_of_range = 1'b1;
            end else begin
                sum              = {7'd0, base} + total;
                res.address      = sum[47:0];
                res.lane_enabled = 1'b1;
            end
            return res;
        endfunction

        task report(input string msg);
            if (errors < MaxPrinted) begin
                $display("ERROR @%0t: %s", $time, msg);
            end
            errors++;
        endtask

        function void note_request(t_lane_request r);
            pending_addresses.push_back(lane_address_of(r));
        endfunction

        task check_result(input logic [47:0] address, input logic [1:0] flags);
            t_lane_result want;
            if (pending_addresses.size() == 0) begin
                report($sformatf("result with no request pending, address %h", address));
                return;
            end
            want = pending_addresses.pop_front();
            if (address !== want.address) begin
                report($sformatf("address %h, expected %h", address, want.address));
            end
            if (flags[0] !== want.lane_enabled) begin
                report($sformatf("lane_enabled %b, expected %b", flags[0],
                                 want.lane_enabled));
            end
            if (flags[1] !== want.out_of_range) begin
                report($sformatf("out_of_range %b, expected %b", flags[1],
                                 want.out_of_range));
            end
        endtask

        function int pending_count();
            return pending_addresses.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [brac_pkg::InDataW-1:0]  i_s_axis_tdata;
    logic [brac_pkg::InUserW-1:0]  i_s_axis_tuser;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [brac_pkg::OutDataW-1:0] o_m_axis_tdata;
    logic [brac_pkg::OutUserW-1:0] o_m_axis_tuser;

    lane_address_board board;
    int                burst_left = 1;
    int                idle_cycles = 0;
    t_ready_mode       rx_mode = READY_ALWAYS;
    int                rx_left = 0;
    int                rx_hold = 0;
    int                rx_phase = 0;

    buffer_resource_address_check_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_lane_request make_request(
        input logic [56:0] base, input logic [44:0] count, input logic [15:0] stride,
        input logic raw, input logic [31:0] v0, input logic [31:0] v1,
        input logic [23:0] ioff, input logic [31:0] soff,
        input logic index_en, input logic offset_en, input logic active);
        t_lane_request r;
        r           = '0;
        r.w0        = base[31:0];
        r.w1        = {count[6:0], base[56:32]};
        r.w2        = count[38:7];
        r.w3        = {raw, 3'd0, stride, 6'd0, count[44:39]};
        r.v0        = v0;
        r.v1        = v1;
        r.ioff      = ioff;
        r.soff      = soff;
        r.index_en  = index_en;
        r.offset_en = offset_en;
        r.active    = active;
        return r;
    endfunction

    function automatic logic [31:0] pick_vector();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 8);
            default: return $urandom_range(0, 70);
        endcase
    endfunction

    function automatic t_lane_request random_request();
        logic [56:0]   base;
        logic [44:0]   count;
        logic [15:0]   stride;
        logic [31:0]   soff;
        int            io;
        t_lane_request r;
        base = 57'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0:             count = '0;
            1, 2, 3, 4, 5: count = 45'($urandom_range(1, 64));
            6, 7:          count = 45'($urandom_range(1, 1048576));
            8:             count = 45'({$urandom, $urandom});
            default:       count = ~45'd0 - 45'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 6))
            0, 1:    stride = '0;
            2, 3, 4: stride = 16'($urandom_range(1, 16));
            default: stride = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       io = int'($urandom_range(0, 16777215)) - 8388608;
            1:       io = $urandom_range(0, 1) ? 8388607 : -8388608;
            default: io = int'($urandom_range(0, 80)) - 40;
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2, 3: soff = '0;
            4, 5:       soff = $urandom_range(0, 16);
            6:          soff = $urandom;
            default:    soff = 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
        r = make_request(base, count, stride, 1'($urandom_range(0, 1)), pick_vector(),
                         pick_vector(), io[23:0], soff, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
        r.w3[11:6]  = 6'($urandom);
        r.w3[30:28] = 3'($urandom);
        return r;
    endfunction

    task automatic drive_request(input t_lane_request r);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, r.active, r.soff, r.ioff, r.v1, r.v0,
                            r.w3, r.w2, r.w1, r.w0};
        i_s_axis_tuser  <= {r.offset_en, r.index_en};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_request(r);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic run_directed();
        t_lane_request r;
        drive_request(make_request('0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        r = make_request('1, '1, '1, 1'b1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
        r.w3[11:6]  = '1;
        r.w3[30:28] = '1;
        drive_request(r);
        r.active = 1'b0;
        drive_request(r);
        // neither enable: vector values ignored
        drive_request(make_request(57'h123_4567_89AB, 45'd200, 16'd4, 1'b1, '1, '1,
                                   24'd100, 32'd0, 1'b0, 1'b0, 1'b1));
        // index only, structured bounds at the record count edge
        drive_request(make_request(57'h1000, 45'd4, 16'd16, 1'b0, 32'd3, '1,
                                   24'd0, 32'd0, 1'b1, 1'b0, 1'b1));
        drive_request(make_request(57'h1000, 45'd4, 16'd16, 1'b0, 32'd4, '1,
                                   24'd0, 32'd0, 1'b1, 1'b0, 1'b1));
        // offset only, raw bounds at the record count edge
        drive_request(make_request(57'h2000, 45'd64, 16'd8, 1'b1, 32'd63, '1,
                                   24'd0, 32'd0, 1'b0, 1'b1, 1'b1));
        drive_request(make_request(57'h2000, 45'd64, 16'd8, 1'b1, 32'd64, '1,
                                   24'd0, 32'd0, 1'b0, 1'b1, 1'b1));
        // both enables
        drive_request(make_request(57'h3000, 45'd10, 16'd8, 1'b0, 32'd2, 32'd5,
                                   24'd3, 32'd7, 1'b1, 1'b1, 1'b1));
        // negative offset, with and without record count
        drive_request(make_request(57'h4000, 45'd100, 16'd0, 1'b1, 32'd10, '0,
                                   -24'sd11, 32'd500, 1'b0, 1'b1, 1'b1));
        drive_request(make_request(57'h4000, 45'd0, 16'd0, 1'b1, 32'd10, '0,
                                   -24'sd11, 32'd500, 1'b0, 1'b1, 1'b1));
        // immediate offset extremes
        drive_request(make_request(57'h5000, 45'd0, 16'd0, 1'b0, 32'd8388608, '0,
                                   24'h800000, 32'd0, 1'b0, 1'b1, 1'b1));
        drive_request(make_request(57'h5000, 45'd0, 16'd0, 1'b0, 32'd0, '0,
                                   24'h7FFFFF, 32'd0, 1'b0, 1'b0, 1'b1));
        drive_request(make_request(57'h5000, 45'd8388607, 16'd0, 1'b1, 32'd0, '0,
                                   24'h7FFFFF, 32'd0, 1'b0, 1'b0, 1'b1));
        // zero record count: large offsets pass
        drive_request(make_request(57'h6000, 45'd0, 16'hFFFF, 1'b0, '1, '1,
                                   24'h7FFFFF, '1, 1'b1, 1'b1, 1'b1));
        // structured mode with zero stride falls back to the offset check
        drive_request(make_request(57'h7000, 45'd32, 16'd0, 1'b0, 32'd1, 32'd32,
                                   24'd0, 32'd0, 1'b1, 1'b1, 1'b1));
        // raw mode ignores the index
        drive_request(make_request(57'h7000, 45'd32, 16'd4, 1'b1, 32'd1000, 32'd31,
                                   24'd0, 32'd0, 1'b1, 1'b1, 1'b1));
        // structured mode ignores the offset
        drive_request(make_request(57'h7000, 45'd32, 16'd4, 1'b0, 32'd31, 32'd1000,
                                   24'd0, 32'd0, 1'b1, 1'b1, 1'b1));
        // address wraps at 48 bits
        drive_request(make_request(57'h0FF_FFFF_FFFF_FFF0, 45'd0, 16'd0, 1'b0, 32'd32, '0,
                                   24'd0, 32'd0, 1'b0, 1'b1, 1'b1));
        drive_request(make_request(57'h1FF_FFFF_FFFF_FFFF, 45'd0, 16'hFFFF, 1'b0, '1, '1,
                                   24'h7FFFFF, '1, 1'b1, 1'b1, 1'b1));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
        if (rx_left == 0) begin
            rx_mode <= t_ready_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            READY_ALWAYS: begin
                i_m_axis_tready <= 1'b1;
            end
            READY_RANDOM: begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
            end
            READY_PATTERN: begin
                i_m_axis_tready <= (rx_phase % 5) < 3;
            end
            default: begin
                if (rx_hold != 0) begin
                    i_m_axis_tready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end else begin
                    i_m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) begin
                        rx_hold <= $urandom_range(1, 12);
                    end
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("FAIL buffer_resource_address_check_unit");
            $finish;
        end
    end

    initial begin
        board = new();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_m_axis_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        repeat (RandomLanes) drive_request(random_request());
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS buffer_resource_address_check_unit");
        end else begin
            $display("FAIL buffer_resource_address_check_unit");
        end
        $finish;
    end

endmodule
